// ===== rtl/core/tpi_pkg.sv =====
// Package for the three-plane intersection block: widths, item and result types and register codes.
`timescale 1ns / 1ps
`default_nettype none
package tpi_pkg;
    localparam int DATA_W  = 32;   // Q16.16 coordinate
    localparam int PROD_W  = 64;   // product of two coordinates
    localparam int CROSS_W = 65;   // cross product component
    localparam int LO_W    = 33;   // low split of a cross component
    localparam int TERM_W  = 97;   // coordinate times cross component
    localparam int SUM_W   = 99;   // dot product of three terms
    localparam int REM_W   = 132;  // divider remainder
    localparam int Q_W     = 34;   // quotient bits produced by the divider
    localparam int EPS_W   = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;
    localparam int ADDR_W  = 2;
    localparam logic [ADDR_W-1:0] ADDR_DET_EPS = 2'd0;

    typedef struct packed {
        logic signed [DATA_W-1:0] a_nx, a_ny, a_nz, a_dist;
        logic signed [DATA_W-1:0] b_nx, b_ny, b_nz, b_dist;
        logic signed [DATA_W-1:0] c_nx, c_ny, c_nz, c_dist;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] x, y, z;
        logic                     found;
        logic                     saturated;
    } t_result;
endpackage
`default_nettype wire

// ===== rtl/core/tpi_front.sv =====
// Front end: accepts plane items into a two-entry queue ahead of the arithmetic pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tpi_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire tpi_pkg::t_item i_item,
    input  wire logic          i_pop,
    output logic               o_avail,
    output tpi_pkg::t_item     o_item
);
    tpi_pkg::t_item r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && o_avail;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_item;
    end
endmodule
`default_nettype wire

// ===== rtl/core/tpi_div_step.sv =====
// One registered step of the restoring divider: tries the shifted divisor once.
`timescale 1ns / 1ps
`default_nettype none
module tpi_div_step #(
    parameter int SHIFT = 0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [tpi_pkg::REM_W-1:0]   i_rem,
    input  wire logic [tpi_pkg::REM_W-1:0]   i_d,
    input  wire logic [tpi_pkg::Q_W-1:0]     i_q,
    output logic      [tpi_pkg::REM_W-1:0]   o_rem,
    output logic      [tpi_pkg::Q_W-1:0]     o_q
);
    logic [tpi_pkg::REM_W-1:0] dsh;
    logic                      take;

    assign dsh  = i_d << SHIFT;
    assign take = (i_rem >= dsh);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= take ? (i_rem - dsh) : i_rem;
            o_q   <= {i_q[tpi_pkg::Q_W-2:0], take};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/tpi_back.sv =====
// Back end: cross and dot products, determinant test, pipelined division and rounding.
`timescale 1ns / 1ps
`default_nettype none
module tpi_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_avail,
    input  wire tpi_pkg::t_item             i_item,
    output logic                            o_pop,
    input  wire logic [tpi_pkg::EPS_W-1:0]  i_eps,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output tpi_pkg::t_result                o_res
);
    localparam int DW = tpi_pkg::DATA_W;
    localparam int RW = tpi_pkg::REM_W;
    localparam int QW = tpi_pkg::Q_W;
    localparam int SW = tpi_pkg::SUM_W;
    localparam int NPRE = 7;
    localparam int NVLD = NPRE + QW;

    logic adv;
    logic [NVLD-1:0] r_vld;
    logic r_out_vld;

    assign adv     = !r_out_vld || !i_stall;
    assign o_pop   = adv;
    assign o_valid = r_out_vld;

    // Columns of the normal matrix and the distance vector.
    logic signed [DW-1:0] m1 [3], m2 [3], m3 [3], dv [3];
    assign m1[0] = i_item.a_nx;   assign m1[1] = i_item.b_nx;   assign m1[2] = i_item.c_nx;
    assign m2[0] = i_item.a_ny;   assign m2[1] = i_item.b_ny;   assign m2[2] = i_item.c_ny;
    assign m3[0] = i_item.a_nz;   assign m3[1] = i_item.b_nz;   assign m3[2] = i_item.c_nz;
    assign dv[0] = i_item.a_dist; assign dv[1] = i_item.b_dist; assign dv[2] = i_item.c_dist;

    logic signed [DW-1:0] r1_m1 [3], r1_m2 [3], r1_m3 [3], r1_dv [3];
    logic signed [DW-1:0] r2_m1 [3], r2_m2 [3], r2_m3 [3], r2_dv [3];
    logic signed [tpi_pkg::PROD_W-1:0] r1_pa [3], r1_pb [3], r1_qa [3], r1_qb [3];
    logic signed [tpi_pkg::CROSS_W-1:0] r2_u [3], r2_v [3];
    logic signed [tpi_pkg::PROD_W-1:0] r3_hi [4][3];
    logic signed [2*tpi_pkg::LO_W-1:0] r3_lo [4][3];
    logic signed [tpi_pkg::TERM_W-1:0] r4_t [4][3];
    logic signed [SW-1:0] r5_s [4];

    genvar k, j;
    generate
        for (k = 0; k < 3; k++) begin : g_cross
            localparam int K1 = (k + 1) % 3;
            localparam int K2 = (k + 2) % 3;
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r1_m1[k] <= m1[k]; r1_m2[k] <= m2[k];
                    r1_m3[k] <= m3[k]; r1_dv[k] <= dv[k];
                    r1_pa[k] <= m2[K1] * m3[K2];
                    r1_pb[k] <= m2[K2] * m3[K1];
                    r1_qa[k] <= m1[K1] * dv[K2];
                    r1_qb[k] <= m1[K2] * dv[K1];
                    r2_m1[k] <= r1_m1[k]; r2_m2[k] <= r1_m2[k];
                    r2_m3[k] <= r1_m3[k]; r2_dv[k] <= r1_dv[k];
                    r2_u[k]  <= {r1_pa[k][63], r1_pa[k]} - {r1_pb[k][63], r1_pb[k]};
                    r2_v[k]  <= {r1_qa[k][63], r1_qa[k]} - {r1_qb[k][63], r1_qb[k]};
                end
            end
            // Dot product terms: determinant, then the three numerators.
            for (j = 0; j < 4; j++) begin : g_term
                logic signed [DW-1:0] a;
                logic signed [tpi_pkg::CROSS_W-1:0] w;
                assign a = (j == 0) ? r2_m1[k] : (j == 1) ? r2_dv[k] :
                           (j == 2) ? r2_m3[k] : r2_m2[k];
                assign w = (j <= 1) ? r2_u[k] : r2_v[k];
                always_ff @(posedge i_clk) begin
                    if (adv) begin
                        r3_hi[j][k] <= a * $signed(w[64:33]);
                        r3_lo[j][k] <= a * $signed({1'b0, w[32:0]});
                        r4_t[j][k]  <= $signed({r3_hi[j][k], 33'b0})
                                     + $signed({{31{r3_lo[j][k][65]}}, r3_lo[j][k]});
                    end
                end
            end
        end
        for (j = 0; j < 4; j++) begin : g_sum
            logic signed [SW-1:0] s;
            assign s = $signed({{2{r4_t[j][0][96]}}, r4_t[j][0]})
                     + $signed({{2{r4_t[j][1][96]}}, r4_t[j][1]})
                     + $signed({{2{r4_t[j][2][96]}}, r4_t[j][2]});
            always_ff @(posedge i_clk) begin
                if (adv) r5_s[j] <= (j == 3) ? -s : s;
            end
        end
    endgenerate

    // Magnitudes, signs and the determinant test.
    logic [SW-1:0] dmag;
    logic [SW-1:0] nmag [3];
    logic [RW-1:0] r6_n [3];
    logic [RW-1:0] r6_d;
    logic [2:0]    r6_neg;
    logic          r6_found;

    assign dmag = r5_s[0][SW-1] ? SW'(-r5_s[0]) : SW'(r5_s[0]);

    generate
        for (k = 0; k < 3; k++) begin : g_mag
            assign nmag[k] = r5_s[k+1][SW-1] ? SW'(-r5_s[k+1]) : SW'(r5_s[k+1]);
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r6_n[k]   <= {17'b0, nmag[k], 16'b0};
                    r6_neg[k] <= r5_s[k+1][SW-1] ^ r5_s[0][SW-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_d     <= {33'b0, dmag};
            r6_found <= (dmag != '0) && !(dmag < {51'b0, i_eps, 32'b0});
        end
    end

    // Stage index s of these arrays feeds divider step s.
    logic [RW-1:0] p_rem [QW+1][3];
    logic [QW-1:0] p_q   [QW+1][3];
    logic [RW-1:0] r_d   [QW+1];
    logic [2:0]    r_neg [QW+1];
    logic [2:0]    r_ovf [QW+1];
    logic          r_fnd [QW+1];

    generate
        for (k = 0; k < 3; k++) begin : g_ovf
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    p_rem[0][k] <= r6_n[k];
                    p_q[0][k]   <= '0;
                    r_ovf[0][k] <= (r6_n[k] >= {r6_d[RW-QW-1:0], {QW{1'b0}}});
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d[0]   <= r6_d;
            r_neg[0] <= r6_neg;
            r_fnd[0] <= r6_found;
        end
    end

    genvar s;
    generate
        for (s = 0; s < QW; s++) begin : g_div
            for (k = 0; k < 3; k++) begin : g_lane
                tpi_div_step #(.SHIFT(QW - 1 - s)) u_step (
                    .i_clk (i_clk),
                    .i_en  (adv),
                    .i_rem (p_rem[s][k]),
                    .i_d   (r_d[s]),
                    .i_q   (p_q[s][k]),
                    .o_rem (p_rem[s+1][k]),
                    .o_q   (p_q[s+1][k])
                );
            end
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_d[s+1]   <= r_d[s];
                    r_neg[s+1] <= r_neg[s];
                    r_ovf[s+1] <= r_ovf[s];
                    r_fnd[s+1] <= r_fnd[s];
                end
            end
        end
    endgenerate

    // Round half away from zero on magnitudes, then clip to Q16.16.
    logic [DW-1:0] coord [3];
    logic [2:0]    sat;
    generate
        for (k = 0; k < 3; k++) begin : g_fin
            logic          rnd;
            logic [QW:0]   qf;
            assign rnd = ({p_rem[QW][k][RW-2:0], 1'b0} >= r_d[QW]);
            assign qf  = {1'b0, p_q[QW][k]} + {{QW{1'b0}}, rnd};
            always_comb begin
                if (!r_neg[QW][k]) begin
                    sat[k]   = r_ovf[QW][k] || (qf > (QW+1)'(32'h7FFF_FFFF));
                    coord[k] = sat[k] ? 32'h7FFF_FFFF : qf[DW-1:0];
                end else begin
                    sat[k]   = r_ovf[QW][k] || (qf > (QW+1)'(32'h8000_0000));
                    coord[k] = sat[k] ? 32'h8000_0000 : DW'(-qf[DW-1:0]);
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_res.found     <= r_fnd[QW];
            o_res.saturated <= r_fnd[QW] && (sat != 3'b0);
            o_res.x         <= r_fnd[QW] ? coord[0] : '0;
            o_res.y         <= r_fnd[QW] ? coord[1] : '0;
            o_res.z         <= r_fnd[QW] ? coord[2] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld     <= {r_vld[NVLD-2:0], i_avail};
            r_out_vld <= r_vld[NVLD-1];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/three_plane_intersection.sv =====
// Top level of the three-plane intersection block: config register, front queue, back pipeline.
//
//  channel   direction  handshake            contents
//  input     in         i_valid / o_stall    three planes, normal and distance, Q16.16
//  result    out        o_valid / i_stall    point, found, saturated
//  config    in         APB psel/penable     det_epsilon at byte address 0
//
// One item per cycle is accepted while the queue is not full; after its item leaves the
// queue, each result passes through the 34 quotient steps of the three pipelined dividers.
// Reset is synchronous, active low; it empties the queue and the pipeline.
// A stalled result freezes the whole pipeline; the queue then takes items until its
// two entries are full.
`timescale 1ns / 1ps
`default_nettype none
module three_plane_intersection (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tpi_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [31:0]            i_plane_a_nx,
    input  wire logic signed [31:0]            i_plane_a_ny,
    input  wire logic signed [31:0]            i_plane_a_nz,
    input  wire logic signed [31:0]            i_plane_a_dist,
    input  wire logic signed [31:0]            i_plane_b_nx,
    input  wire logic signed [31:0]            i_plane_b_ny,
    input  wire logic signed [31:0]            i_plane_b_nz,
    input  wire logic signed [31:0]            i_plane_b_dist,
    input  wire logic signed [31:0]            i_plane_c_nx,
    input  wire logic signed [31:0]            i_plane_c_ny,
    input  wire logic signed [31:0]            i_plane_c_nz,
    input  wire logic signed [31:0]            i_plane_c_dist,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [31:0]                 o_point_x,
    output logic signed [31:0]                 o_point_y,
    output logic signed [31:0]                 o_point_z,
    output logic                               o_found,
    output logic                               o_saturated
);
    logic [tpi_pkg::EPS_W-1:0] r_det_eps;
    tpi_pkg::t_item   in_item, q_item;
    tpi_pkg::t_result res;
    logic q_avail, q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr == tpi_pkg::ADDR_DET_EPS) ? {16'b0, r_det_eps} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_eps <= tpi_pkg::EPS_RESET;
        end else if (psel && penable && pwrite && paddr == tpi_pkg::ADDR_DET_EPS) begin
            r_det_eps <= pwdata[tpi_pkg::EPS_W-1:0];
        end
    end

    assign in_item = '{a_nx: i_plane_a_nx, a_ny: i_plane_a_ny, a_nz: i_plane_a_nz,
                       a_dist: i_plane_a_dist, b_nx: i_plane_b_nx, b_ny: i_plane_b_ny,
                       b_nz: i_plane_b_nz, b_dist: i_plane_b_dist, c_nx: i_plane_c_nx,
                       c_ny: i_plane_c_ny, c_nz: i_plane_c_nz, c_dist: i_plane_c_dist};

    tpi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (in_item),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_item  (q_item)
    );

    tpi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (q_avail),
        .i_item  (q_item),
        .o_pop   (q_pop),
        .i_eps   (r_det_eps),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (res)
    );

    assign o_point_x   = res.x;
    assign o_point_y   = res.y;
    assign o_point_z   = res.z;
    assign o_found     = res.found;
    assign o_saturated = res.saturated;

    a_sat_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_found)
        else $error("saturated result without an intersection");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> (o_point_x == 0 && o_point_y == 0 && o_point_z == 0))
        else $error("missed intersection with nonzero point");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");
endmodule
`default_nettype wire

// ===== tb/sv/three_plane_intersection_tb.sv =====
// Self-checking testbench for the three-plane intersection block.
`timescale 1ns / 1ps

class point_scoreboard;
    tpi_pkg::t_result pending[$];
    logic [tpi_pkg::EPS_W-1:0] eps;
    int errors;

    function new();
        eps = tpi_pkg::EPS_RESET;
        errors = 0;
    endfunction

    // Rounded num * 2^16 / den, ties away from zero, clipped to Q16.16.
    function logic [31:0] divide_q16(logic signed [199:0] num, logic signed [199:0] den,
                                     ref logic sat);
        logic neg;
        logic [199:0] n, d, q, r;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        n = n << 16;
        q = n / d;
        r = n % d;
        if ((r << 1) >= d) q = q + 1;
        if (!neg) begin
            if (q > 200'h7FFFFFFF) begin
                sat = 1'b1;
                return 32'h7FFFFFFF;
            end
            return q[31:0];
        end
        if (q > 200'h80000000) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return -q[31:0];
    endfunction

    function void note_item(tpi_pkg::t_item it);
        logic signed [199:0] m1[3], m2[3], m3[3], dv[3], u[3], v[3];
        logic signed [199:0] den, thr, mag;
        tpi_pkg::t_result res;
        logic sat;
        m1[0] = it.a_nx; m1[1] = it.b_nx; m1[2] = it.c_nx;
        m2[0] = it.a_ny; m2[1] = it.b_ny; m2[2] = it.c_ny;
        m3[0] = it.a_nz; m3[1] = it.b_nz; m3[2] = it.c_nz;
        dv[0] = it.a_dist; dv[1] = it.b_dist; dv[2] = it.c_dist;
        u[0] = m2[1] * m3[2] - m2[2] * m3[1];
        u[1] = m2[2] * m3[0] - m2[0] * m3[2];
        u[2] = m2[0] * m3[1] - m2[1] * m3[0];
        den = m1[0] * u[0] + m1[1] * u[1] + m1[2] * u[2];
        thr = 200'(eps) << 32;
        mag = (den < 0) ? -den : den;
        res = '0;
        sat = 1'b0;
        if (den != 0 && mag >= thr) begin
            v[0] = m1[1] * dv[2] - m1[2] * dv[1];
            v[1] = m1[2] * dv[0] - m1[0] * dv[2];
            v[2] = m1[0] * dv[1] - m1[1] * dv[0];
            res.x = divide_q16(dv[0] * u[0] + dv[1] * u[1] + dv[2] * u[2], den, sat);
            res.y = divide_q16(m3[0] * v[0] + m3[1] * v[1] + m3[2] * v[2], den, sat);
            res.z = divide_q16(-(m2[0] * v[0] + m2[1] * v[1] + m2[2] * v[2]), den, sat);
            res.found = 1'b1;
            res.saturated = sat;
        end
        pending.insert(pending.size(), res);
    endfunction

    function void check_result(tpi_pkg::t_result got);
        tpi_pkg::t_result exp_r;
        if (pending.size() == 0) begin
            $error("result with no item outstanding");
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.x !== exp_r.x) begin
            $error("point_x expected %h actual %h", exp_r.x, got.x); errors++;
        end
        if (got.y !== exp_r.y) begin
            $error("point_y expected %h actual %h", exp_r.y, got.y); errors++;
        end
        if (got.z !== exp_r.z) begin
            $error("point_z expected %h actual %h", exp_r.z, got.z); errors++;
        end
        if (got.found !== exp_r.found) begin
            $error("found expected %b actual %b", exp_r.found, got.found); errors++;
        end
        if (got.saturated !== exp_r.saturated) begin
            $error("saturated expected %b actual %b", exp_r.saturated, got.saturated);
            errors++;
        end
    endfunction
endclass

module three_plane_intersection_tb;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [tpi_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0, o_stall, o_valid, i_stall = 1'b0;
    logic signed [31:0] o_point_x, o_point_y, o_point_z;
    logic o_found, o_saturated;
    tpi_pkg::t_item cur = '0;
    tpi_pkg::t_result got;
    int idle_pct = 0, stall_pct = 0;
    point_scoreboard sb = new();

    always #5 i_clk = ~i_clk;

    three_plane_intersection dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_plane_a_nx(cur.a_nx), .i_plane_a_ny(cur.a_ny),
        .i_plane_a_nz(cur.a_nz), .i_plane_a_dist(cur.a_dist),
        .i_plane_b_nx(cur.b_nx), .i_plane_b_ny(cur.b_ny),
        .i_plane_b_nz(cur.b_nz), .i_plane_b_dist(cur.b_dist),
        .i_plane_c_nx(cur.c_nx), .i_plane_c_ny(cur.c_ny),
        .i_plane_c_nz(cur.c_nz), .i_plane_c_dist(cur.c_dist),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_point_x(o_point_x), .o_point_y(o_point_y), .o_point_z(o_point_z),
        .o_found(o_found), .o_saturated(o_saturated)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_item(cur);
            if (o_valid && !i_stall) begin
                got.x = o_point_x;
                got.y = o_point_y;
                got.z = o_point_z;
                got.found = o_found;
                got.saturated = o_saturated;
                sb.check_result(got);
            end
        end
    end

    always @(negedge i_clk) i_stall <= ($urandom_range(99) < stall_pct);

    task automatic write_eps(logic [tpi_pkg::EPS_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= tpi_pkg::ADDR_DET_EPS; pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        // The address still selects the register, so its new value reads back.
        if (pready !== 1'b1 || prdata !== 32'(value)) begin
            $error("det_epsilon expected %h actual %h", 32'(value), prdata);
            sb.errors++;
        end
        sb.eps = value;
    endtask

    // Drive one item and hold it until it is taken.
    task automatic send_item(tpi_pkg::t_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        cur <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic tpi_pkg::t_item diag(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                   logic [31:0] da, logic [31:0] db, logic [31:0] dc);
        tpi_pkg::t_item it;
        it = '0;
        it.a_nx = x; it.b_ny = y; it.c_nz = z;
        it.a_dist = da; it.b_dist = db; it.c_dist = dc;
        return it;
    endfunction

    task automatic send_directed();
        tpi_pkg::t_item it;
        send_item('0);
        send_item(diag(32'h10000, 32'h10000, 32'h10000, 32'h30000, 32'hFFFE0000, 32'h8000));
        send_item(diag(32'h10000, 32'h10000, 32'h10000, 32'h7FFFFFFF, 32'h80000000, 32'h1));
        send_item(diag(32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h7FFFFFFF, 32'h80000000));
        // A small determinant with a large distance drives the x coordinate past its limit.
        send_item(diag(32'h1, 32'h10000, 32'h10000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
        send_item(diag(32'hFFFFFFFF, 32'h10000, 32'h10000, 32'h80000000, 32'h7FFFFFFF, 32'h0));
        // A determinant of 2^17 with an odd distance lands exactly on a half.
        send_item(diag(32'h20000, 32'h1, 32'h1, 32'h1, 32'h0, 32'h0));
        send_item(diag(32'h20000, 32'h1, 32'h1, 32'hFFFFFFFF, 32'h0, 32'h0));
        it = {12{32'h7FFFFFFF}};
        send_item(it);
        it = {12{32'h80000000}};
        send_item(it);
        it = diag(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
        it.c_nx = it.a_nx; it.c_ny = it.a_ny; it.c_nz = it.a_nz;
        send_item(it);
    endtask

    function automatic logic [31:0] pick_coord(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(32'h80000)) - 32'sh40000);
            default: return 32'($signed($urandom_range(64)) - 32);
        endcase
    endfunction

    task automatic send_random(int count);
        tpi_pkg::t_item it;
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(9);
            for (int f = 0; f < 12; f++)
                it[f*32 +: 32] = pick_coord(kind < 3 ? 0 : (kind < 8 ? 1 : 2));
            // Make the normals linearly dependent now and then.
            if (kind == 9) begin
                it.c_nx = it.a_nx; it.c_ny = it.a_ny; it.c_nz = it.a_nz;
            end
            send_item(it);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        logic [tpi_pkg::EPS_W-1:0] eps_set[6];
        int idle_set[4], stall_set[4];
        eps_set = '{tpi_pkg::EPS_RESET, 16'd0, 16'hFFFF, 16'd1, 16'($urandom()), 16'd0};
        idle_set = '{0, 50, 0, 10};
        stall_set = '{0, 0, 50, 10};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            write_eps(eps_set[ph]);
            idle_pct = 0;
            stall_pct = 0;
            if (ph < 2) send_directed();
            for (int s = 0; s < 4; s++) begin
                idle_pct = idle_set[s];
                stall_pct = stall_set[s];
                send_random(30);
            end
            stall_pct = 0;
            drain();
        end
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("three_plane_intersection verification clean");
        end else begin
            $display("three_plane_intersection verification failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("three_plane_intersection verification failed");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/tpi_pkg.sv
rtl/core/tpi_front.sv
rtl/core/tpi_div_step.sv
rtl/core/tpi_back.sv
rtl/core/three_plane_intersection.sv
tb/sv/three_plane_intersection_tb.sv
